// ===== src/ddpq_pkg.sv =====
`timescale 1ns / 1ps

package ddpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [3:0] month;
		logic [4:0] day;
		logic [9:0] points;
		logic [7:0] tag;
	} entry_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef struct packed {
		logic shift_in;
		logic shift_out;
	} cell_ctrl_t;

	// true when a does not rank below b
	function automatic logic ranks_at_least(entry_t a, entry_t b);
		logic r;
		if (a.month != b.month) begin
			r = a.month < b.month;
		end else if (a.day != b.day) begin
			r = a.day < b.day;
		end else begin
			r = a.points >= b.points;
		end
		return r;
	endfunction

endpackage

// ===== src/ddpq_cell.sv =====
`timescale 1ns / 1ps

module ddpq_cell (
	input  logic                  clk,
	input  ddpq_pkg::cell_ctrl_t  ctrl,
	input  ddpq_pkg::entry_t      new_entry,
	input  logic                  occupied,
	input  logic                  left_take,
	input  ddpq_pkg::entry_t      left_entry,
	input  ddpq_pkg::entry_t      right_entry,
	output logic                  take,
	output ddpq_pkg::entry_t      entry_q
);

	// the new entry belongs here or ahead of here
	assign take = !occupied || ddpq_pkg::ranks_at_least(new_entry, entry_q);

	always_ff @(posedge clk) begin
		if (ctrl.shift_in && take) begin
			// neighbour ahead also yields: its entry moves down to us
			entry_q <= left_take ? left_entry : new_entry;
		end else if (ctrl.shift_out) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== src/due_date_priority_queue_top.sv =====
`timescale 1ns / 1ps

// each accepted input beat gives a registered result beat in the cycle after it is accepted
// throughput: one item per cycle while results are drained; every cell compares against the broadcast key at once
// a new beat is taken whenever the result register is empty or being drained
// reset clears the entry count and the result valid; cell contents are not cleared
module due_date_priority_queue_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [3:0]  due_month,
	input  logic [4:0]  due_day,
	input  logic [9:0]  point_value,
	input  logic [7:0]  entry_tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [3:0]  removed_month,
	output logic [4:0]  removed_day,
	output logic [9:0]  removed_points,
	output logic [7:0]  removed_tag,
	output logic [3:0]  head_month,
	output logic [4:0]  head_day,
	output logic [9:0]  head_points,
	output logic [7:0]  head_tag,
	output logic [4:0]  entry_count,
	output logic        queue_empty
);

	logic [ddpq_pkg::CNT_W-1:0] count_q;
	logic                       out_valid_q;
	ddpq_pkg::status_t          status_q;
	ddpq_pkg::entry_t           removed_q;

	ddpq_pkg::entry_t     new_entry;
	ddpq_pkg::cell_ctrl_t ctrl;
	ddpq_pkg::entry_t     cell_entry [ddpq_pkg::QUEUE_DEPTH];
	logic [ddpq_pkg::QUEUE_DEPTH-1:0] cell_take;

	logic accept, is_remove, full, empty;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign is_remove = operation == ddpq_pkg::OP_REMOVE;
	assign full      = count_q == ddpq_pkg::CNT_W'(ddpq_pkg::QUEUE_DEPTH);
	assign empty     = count_q == '0;

	assign new_entry = '{month: due_month, day: due_day, points: point_value, tag: entry_tag};

	always_comb begin
		ctrl.shift_in  = accept && !is_remove && !full;
		ctrl.shift_out = accept && is_remove && !empty;
	end

	for (genvar i = 0; i < ddpq_pkg::QUEUE_DEPTH; i++) begin : g_cell
		logic             left_take;
		ddpq_pkg::entry_t left_entry;
		ddpq_pkg::entry_t right_entry;

		if (i == 0) begin : g_head
			assign left_take  = 1'b0;
			assign left_entry = new_entry;
		end else begin : g_mid
			assign left_take  = cell_take[i-1];
			assign left_entry = cell_entry[i-1];
		end

		if (i == ddpq_pkg::QUEUE_DEPTH - 1) begin : g_tail
			assign right_entry = cell_entry[i];
		end else begin : g_body
			assign right_entry = cell_entry[i+1];
		end

		ddpq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.new_entry   (new_entry),
			.occupied    (count_q > ddpq_pkg::CNT_W'(i)),
			.left_take   (left_take),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.take        (cell_take[i]),
			.entry_q     (cell_entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.shift_in) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.shift_out) begin
				count_q <= count_q - 1'b1;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!is_remove && full) begin
				status_q <= ddpq_pkg::ST_FULL;
			end else if (is_remove && empty) begin
				status_q <= ddpq_pkg::ST_EMPTY;
			end else begin
				status_q <= ddpq_pkg::ST_OK;
			end
			removed_q <= ctrl.shift_out ? cell_entry[0] : '0;
		end
	end

	// head comes straight from the front cell and count from the entry counter: state only moves with a new result beat
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign removed_month  = removed_q.month;
	assign removed_day    = removed_q.day;
	assign removed_points = removed_q.points;
	assign removed_tag    = removed_q.tag;
	assign head_month     = empty ? 4'd0 : cell_entry[0].month;
	assign head_day       = empty ? 5'd0 : cell_entry[0].day;
	assign head_points    = empty ? 10'd0 : cell_entry[0].points;
	assign head_tag       = empty ? 8'd0 : cell_entry[0].tag;
	assign entry_count    = 5'(count_q);
	assign queue_empty    = empty;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ddpq_pkg::CNT_W'(ddpq_pkg::QUEUE_DEPTH))
		else $error("entry count beyond depth");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_remove && full) |=> ($stable(count_q) && status_q == ddpq_pkg::ST_FULL))
		else $error("insert into full queue changed state");

	a_empty_remove: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_remove && empty) |=> (count_q == '0 && status_q == ddpq_pkg::ST_EMPTY
			&& removed_q == '0))
		else $error("remove from empty queue misreported");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> ($stable(count_q) && $stable(removed_q)))
		else $error("state moved while result beat stalled");

endmodule
